// File: rtl/sparse_column_metric_accumulator_macros.svh
// assertion macros for the sparse column metric accumulator
`ifndef SPARSE_COLUMN_METRIC_ACCUMULATOR_MACROS_SVH
`define SPARSE_COLUMN_METRIC_ACCUMULATOR_MACROS_SVH
`ifndef SYNTHESIS
`define SCMA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");
`define SCMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");
`else
`define SCMA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SCMA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/scma_pkg.sv
// shared types and constants for the sparse column metric accumulator
`default_nettype none
package scma_pkg;

    localparam int COLUMNS_DEF     = 4096;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int CFG_AW          = 5;

    // register indexes, byte address 4*i
    localparam logic [2:0] REG_ROW_COUNT    = 3'd0;
    localparam logic [2:0] REG_COL_COUNT    = 3'd1;
    localparam logic [2:0] REG_ENTRY_TOTAL  = 3'd2;
    localparam logic [2:0] REG_FEATURE_ROWS = 3'd3;
    localparam logic [2:0] REG_SUBSET_FIRST = 3'd4;
    localparam logic [2:0] REG_SUBSET_LAST  = 3'd5;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_BAD        = 3'd1,
        ERR_ORDER      = 3'd2,
        ERR_TOTAL_OVF  = 3'd3,
        ERR_SUBSET_OVF = 3'd4,
        ERR_TOO_MANY   = 3'd5
    } err_t;

    // checks done on the accept cycle, consumed on the update cycle
    typedef struct packed {
        logic is_read;
        logic col_ok;
        logic too_many;
        logic bad;
        logic order_err;
        logic feature;
        logic in_sub;
    } chk_t;

endpackage
`default_nettype wire

// File: rtl/sparse_column_metric_accumulator.sv
// top level: configuration registers, control sequence and column store
//
// For each item (an entry or a column read), on the accept cycle the column word is
// read from the store and the entry checks are registered, on the next cycle the
// word is updated and written back and the result is registered.
// The result shows on the ports with done high for one cycle, and busy is low again
// in that cycle so the next item can be taken right away; a new item is not taken
// while the last one is in its update cycle, as the read-modify-write of the column
// store has no forwarding path. The receiver cannot stall the block: every result
// must be taken in its done cycle.
// After reset the store is cleared one column per cycle with busy high;
// configuration writes are taken during that sweep.
`default_nettype none
`include "sparse_column_metric_accumulator_macros.svh"
module sparse_column_metric_accumulator
    import scma_pkg::*;
#(
    parameter int COLUMNS     = COLUMNS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              mode,
    input  wire logic [31:0]       row_index,
    input  wire logic [15:0]       col_index,
    input  wire logic [31:0]       entry_value,
    output logic                   done,
    output logic [31:0]            total_sum,
    output logic [31:0]            hit_count,
    output logic [31:0]            subset_sum,
    output logic [2:0]             error_code,
    output logic                   entries_complete,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int AW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int WORD_W = 3 * COUNT_WIDTH;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [AW-1:0]    clr_addr_reg;
    logic [AW-1:0]    clr_addr_next;

    logic [31:0]      row_count_reg;
    logic [12:0]      col_count_reg;
    logic [31:0]      entry_total_reg;
    logic [31:0]      feature_rows_reg;
    logic [31:0]      subset_first_reg;
    logic [31:0]      subset_last_reg;

    logic [31:0]      last_row_reg;
    logic [31:0]      last_row_next;
    logic [15:0]      last_col_reg;
    logic [15:0]      last_col_next;
    logic [31:0]      seen_reg;
    logic [31:0]      seen_next;
    err_t             err_reg;
    err_t             err_next;

    logic             done_reg;
    logic             done_next;
    logic [31:0]      total_reg;
    logic [31:0]      total_next;
    logic [31:0]      hit_reg;
    logic [31:0]      hit_next;
    logic [31:0]      subset_reg;
    logic [31:0]      subset_next;
    logic             complete_reg;
    logic             complete_next;

    logic             accept;
    logic             cfg_write;
    logic [2:0]       cfg_idx;

    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    item_addr_reg;
    chk_t             chk_reg;
    logic [31:0]      row_reg;
    logic [15:0]      col_reg;
    logic [31:0]      val_reg;

    logic [WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0] upd_wdata;
    logic [WORD_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_waddr;
    logic              ram_we;
    logic              upd_we;
    logic              pos_update;
    err_t              upd_err;
    logic [31:0]       upd_total;
    logic [31:0]       upd_hit;
    logic [31:0]       upd_subset;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[CFG_AW-1:2];

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= 32'd1;
            col_count_reg    <= 13'd4096;
            entry_total_reg  <= 32'd1;
            feature_rows_reg <= 32'd1;
            subset_first_reg <= 32'd1;
            subset_last_reg  <= 32'd1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_ROW_COUNT:    row_count_reg    <= pwdata;
                REG_COL_COUNT:    col_count_reg    <= pwdata[12:0];
                REG_ENTRY_TOTAL:  entry_total_reg  <= pwdata;
                REG_FEATURE_ROWS: feature_rows_reg <= pwdata;
                REG_SUBSET_FIRST: subset_first_reg <= pwdata;
                REG_SUBSET_LAST:  subset_last_reg  <= pwdata;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_ROW_COUNT:    prdata = row_count_reg;
            REG_COL_COUNT:    prdata = {19'd0, col_count_reg};
            REG_ENTRY_TOTAL:  prdata = entry_total_reg;
            REG_FEATURE_ROWS: prdata = feature_rows_reg;
            REG_SUBSET_FIRST: prdata = subset_first_reg;
            REG_SUBSET_LAST:  prdata = subset_last_reg;
            default:          prdata = 32'd0;
        endcase
    end

    scma_check #(
        .COLUMNS (COLUMNS),
        .AW      (AW)
    ) u_check (
        .clk          (clk),
        .capture      (accept),
        .mode         (mode),
        .row_index    (row_index),
        .col_index    (col_index),
        .entry_value  (entry_value),
        .row_count    (row_count_reg),
        .col_count    (col_count_reg),
        .entry_total  (entry_total_reg),
        .feature_rows (feature_rows_reg),
        .subset_first (subset_first_reg),
        .subset_last  (subset_last_reg),
        .last_row     (last_row_reg),
        .last_col     (last_col_reg),
        .entries_seen (seen_reg),
        .addr         (rd_addr),
        .chk_reg      (chk_reg),
        .row_reg      (row_reg),
        .col_reg      (col_reg),
        .val_reg      (val_reg)
    );

    scma_update #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_update (
        .rdata      (ram_rdata),
        .chk        (chk_reg),
        .val        (val_reg),
        .err_cur    (err_reg),
        .err_new    (upd_err),
        .store_we   (upd_we),
        .pos_update (pos_update),
        .wdata      (upd_wdata),
        .total_out  (upd_total),
        .hit_out    (upd_hit),
        .subset_out (upd_subset)
    );

    // write port: zero sweep after reset, else write-back of the update cycle
    assign ram_we    = (state_reg == S_CLEAR) || ((state_reg == S_EXEC) && upd_we);
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_addr_reg : item_addr_reg;
    assign ram_wdata = (state_reg == S_CLEAR) ? '0 : upd_wdata;

    scma_ram #(
        .WIDTH (WORD_W),
        .DEPTH (COLUMNS),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        last_row_next = last_row_reg;
        last_col_next = last_col_reg;
        seen_next     = seen_reg;
        err_next      = err_reg;
        done_next     = 1'b0;
        total_next    = total_reg;
        hit_next      = hit_reg;
        subset_next   = subset_reg;
        complete_next = complete_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == AW'(COLUMNS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                err_next   = upd_err;
                if (pos_update)
                begin
                    last_row_next = row_reg;
                    last_col_next = col_reg;
                    seen_next     = seen_reg + 32'd1;
                end
                done_next     = 1'b1;
                total_next    = upd_total;
                hit_next      = upd_hit;
                subset_next   = upd_subset;
                complete_next = (seen_next == entry_total_reg);
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            last_row_reg  <= 32'd0;
            last_col_reg  <= 16'd0;
            seen_reg      <= 32'd0;
            err_reg       <= ERR_NONE;
            done_reg      <= 1'b0;
            total_reg     <= 32'd0;
            hit_reg       <= 32'd0;
            subset_reg    <= 32'd0;
            complete_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            last_row_reg  <= last_row_next;
            last_col_reg  <= last_col_next;
            seen_reg      <= seen_next;
            err_reg       <= err_next;
            done_reg      <= done_next;
            total_reg     <= total_next;
            hit_reg       <= hit_next;
            subset_reg    <= subset_next;
            complete_reg  <= complete_next;
        end
    end

    // write-back address follows the item through the update cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_addr_reg <= rd_addr;
        end
    end

    assign done             = done_reg;
    assign total_sum        = total_reg;
    assign hit_count        = hit_reg;
    assign subset_sum       = subset_reg;
    assign error_code       = err_reg;
    assign entries_complete = complete_reg;

    `SCMA_ASSERT_NEXT(a_accept_to_exec, clk, rst_n, accept, state_reg == S_EXEC && busy)
    `SCMA_ASSERT_NEXT(a_error_sticky, clk, rst_n, err_reg != ERR_NONE, err_reg == $past(err_reg))
    `SCMA_ASSERT_NEXT(a_seen_step, clk, rst_n, 1'b1, (seen_reg == $past(seen_reg)) || (seen_reg == $past(seen_reg) + 32'd1))
    `SCMA_ASSERT_SAME(a_no_result_in_clear, clk, rst_n, state_reg == S_CLEAR, !done && !accept)
    `SCMA_ASSERT_SAME(a_write_only_update, clk, rst_n, ram_we && state_reg != S_CLEAR, state_reg == S_EXEC && !chk_reg.is_read)

endmodule
`default_nettype wire

// File: rtl/scma_ram.sv
// generic single-clock ram, one write port and one registered read port
`default_nettype none
module scma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: rtl/scma_check.sv
// entry checks and item capture on the accept cycle
`default_nettype none
module scma_check
    import scma_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int AW      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1
) (
    input  wire logic          clk,
    input  wire logic          capture,
    input  wire logic          mode,
    input  wire logic [31:0]   row_index,
    input  wire logic [15:0]   col_index,
    input  wire logic [31:0]   entry_value,
    input  wire logic [31:0]   row_count,
    input  wire logic [12:0]   col_count,
    input  wire logic [31:0]   entry_total,
    input  wire logic [31:0]   feature_rows,
    input  wire logic [31:0]   subset_first,
    input  wire logic [31:0]   subset_last,
    input  wire logic [31:0]   last_row,
    input  wire logic [15:0]   last_col,
    input  wire logic [31:0]   entries_seen,
    output logic [AW-1:0]      addr,
    output chk_t               chk_reg,
    output logic [31:0]        row_reg,
    output logic [15:0]        col_reg,
    output logic [31:0]        val_reg
);

    chk_t          chk_next;
    logic          col_ok;
    logic [AW-1:0] addr_next;

    assign col_ok = (col_index != 16'd0)
                 && ({3'b000, col_count} >= col_index)
                 && ({16'd0, col_index} <= 32'(COLUMNS));

    assign addr_next = AW'({16'd0, col_index} - 32'd1);
    // read address goes straight to the ram on the accept cycle
    assign addr = addr_next;

    always_comb
    begin
        chk_next.is_read   = mode;
        chk_next.col_ok    = col_ok;
        chk_next.too_many  = entries_seen >= entry_total;
        chk_next.bad       = (row_index == 32'd0) || (row_index > row_count)
                          || !col_ok || (entry_value == 32'd0);
        chk_next.order_err = (entries_seen != 32'd0)
                          && ((col_index < last_col)
                           || ((col_index == last_col) && (row_index <= last_row)));
        chk_next.feature   = row_index <= feature_rows;
        chk_next.in_sub    = (row_index >= subset_first) && (row_index <= subset_last);
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            chk_reg <= chk_next;
            row_reg <= row_index;
            col_reg <= col_index;
            val_reg <= entry_value;
        end
    end

endmodule
`default_nettype wire

// File: rtl/scma_update.sv
// read-modify-write decision for one item, from the ram word and the checks
`default_nettype none
module scma_update
    import scma_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int SUM_W       = ((COUNT_WIDTH > 32) ? COUNT_WIDTH : 32) + 1
) (
    input  wire logic [3*COUNT_WIDTH-1:0] rdata,
    input  wire chk_t                     chk,
    input  wire logic [31:0]              val,
    input  wire err_t                     err_cur,
    output err_t                          err_new,
    output logic                          store_we,
    output logic                          pos_update,
    output logic [3*COUNT_WIDTH-1:0]      wdata,
    output logic [31:0]                   total_out,
    output logic [31:0]                   hit_out,
    output logic [31:0]                   subset_out
);

    logic [COUNT_WIDTH-1:0] total_q;
    logic [COUNT_WIDTH-1:0] hit_q;
    logic [COUNT_WIDTH-1:0] sub_q;
    logic [SUM_W-1:0]       total_sum;
    logic [SUM_W-1:0]       sub_sum;
    logic                   total_ovf;
    logic                   sub_ovf;

    assign total_q = rdata[3*COUNT_WIDTH-1:2*COUNT_WIDTH];
    assign hit_q   = rdata[2*COUNT_WIDTH-1:COUNT_WIDTH];
    assign sub_q   = rdata[COUNT_WIDTH-1:0];

    assign total_sum = SUM_W'(total_q) + SUM_W'(val);
    assign sub_sum   = SUM_W'(sub_q) + SUM_W'(val);
    // overflow when any bit above the counter width is set
    assign total_ovf = |total_sum[SUM_W-1:COUNT_WIDTH];
    assign sub_ovf   = |sub_sum[SUM_W-1:COUNT_WIDTH];

    assign wdata = {total_sum[COUNT_WIDTH-1:0],
                    hit_q + COUNT_WIDTH'(1),
                    chk.in_sub ? sub_sum[COUNT_WIDTH-1:0] : sub_q};

    assign total_out  = (chk.is_read && chk.col_ok) ? 32'(total_q) : 32'd0;
    assign hit_out    = (chk.is_read && chk.col_ok) ? 32'(hit_q)   : 32'd0;
    assign subset_out = (chk.is_read && chk.col_ok) ? 32'(sub_q)   : 32'd0;

    always_comb
    begin
        err_new    = err_cur;
        store_we   = 1'b0;
        pos_update = 1'b0;
        if (!chk.is_read && (err_cur == ERR_NONE))
        begin
            if (chk.too_many)
            begin
                err_new = ERR_TOO_MANY;
            end
            else if (chk.bad)
            begin
                err_new = ERR_BAD;
            end
            else if (chk.order_err)
            begin
                err_new = ERR_ORDER;
            end
            else if (chk.feature)
            begin
                if (total_ovf)
                begin
                    err_new = ERR_TOTAL_OVF;
                end
                else if (chk.in_sub && sub_ovf)
                begin
                    err_new = ERR_SUBSET_OVF;
                end
                else
                begin
                    store_we   = 1'b1;
                    pos_update = 1'b1;
                end
            end
            else
            begin
                pos_update = 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: verif/sparse_column_metric_accumulator_tb.sv
// self-checking testbench for the sparse column metric accumulator
`timescale 1ns / 1ps
module sparse_column_metric_accumulator_tb;
    import scma_pkg::*;

    localparam int          NCOL           = COLUMNS_DEF;
    localparam int          RANDOM_ITEMS   = 1000;
    localparam int          NOISE_ITEMS    = 80;
    localparam int          WATCHDOG_LIMIT = 20000;
    localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;
    // indexes past the register list, writes there must be dropped
    localparam logic [2:0]  REG_SPARE_A    = 3'd6;
    localparam logic [2:0]  REG_SPARE_B    = 3'd7;

    typedef struct {
        logic [31:0] total;
        logic [31:0] hits;
        logic [31:0] subset;
        err_t        err;
        logic        complete;
    } column_report_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              mode = 1'b0;
    logic [31:0]       row_index = '0;
    logic [15:0]       col_index = '0;
    logic [31:0]       entry_value = '0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic              busy;
    logic              done;
    logic [31:0]       total_sum;
    logic [31:0]       hit_count;
    logic [31:0]       subset_sum;
    logic [2:0]        error_code;
    logic              entries_complete;
    logic [31:0]       prdata;
    logic              pready;

    sparse_column_metric_accumulator dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .mode             (mode),
        .row_index        (row_index),
        .col_index        (col_index),
        .entry_value      (entry_value),
        .done             (done),
        .total_sum        (total_sum),
        .hit_count        (hit_count),
        .subset_sum       (subset_sum),
        .error_code       (error_code),
        .entries_complete (entries_complete),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // shadow registers
    logic [31:0] cfg_rows         = 32'd1;
    logic [12:0] cfg_cols         = 13'd4096;
    logic [31:0] cfg_entry_total  = 32'd1;
    logic [31:0] cfg_feature_rows = 32'd1;
    logic [31:0] cfg_sub_first    = 32'd1;
    logic [31:0] cfg_sub_last     = 32'd1;

    // shadow column store and stream state
    logic [31:0] col_total  [NCOL];
    logic [31:0] col_hits   [NCOL];
    logic [31:0] col_subset [NCOL];
    logic [31:0] prev_row = '0;
    logic [15:0] prev_col = '0;
    logic [31:0] accepted_entries = '0;
    err_t        latched_err = ERR_NONE;

    column_report_t column_reports_due[$];

    int unsigned n_sent     = 0;
    int unsigned n_reads    = 0;
    int unsigned n_checked  = 0;
    int unsigned n_mismatch = 0;
    int unsigned idle_cycles = 0;
    bit          burst = 1'b0;

    initial begin
        for (int i = 0; i < NCOL; i++) begin
            col_total[i]  = '0;
            col_hits[i]   = '0;
            col_subset[i] = '0;
        end
    end

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic bit col_usable(input logic [15:0] col);
        return col != 16'd0 && col <= cfg_cols && col <= NCOL;
    endfunction

    // advances the shadow state by one item and returns the report it must produce
    function automatic column_report_t column_report_for(input logic m, input logic [31:0] row,
                                                         input logic [15:0] col,
                                                         input logic [31:0] val);
        column_report_t rep;
        int unsigned    ci;
        logic [32:0]    tsum;
        logic [32:0]    ssum;
        logic           feat;
        logic           sub;
        rep.total  = '0;
        rep.hits   = '0;
        rep.subset = '0;
        if (m == 1'b0) begin
            if (latched_err != ERR_NONE) begin
                // error latched, entry dropped
            end else if (accepted_entries >= cfg_entry_total) begin
                latched_err = ERR_TOO_MANY;
            end else if (row == 0 || row > cfg_rows || !col_usable(col) || val == 0) begin
                latched_err = ERR_BAD;
            end else if (accepted_entries != 0 &&
                         (col < prev_col || (col == prev_col && row <= prev_row))) begin
                latched_err = ERR_ORDER;
            end else begin
                ci   = col - 1;
                feat = row <= cfg_feature_rows;
                sub  = feat && row >= cfg_sub_first && row <= cfg_sub_last;
                tsum = {1'b0, col_total[ci]} + val;
                ssum = {1'b0, col_subset[ci]} + val;
                if (feat && tsum[32]) begin
                    latched_err = ERR_TOTAL_OVF;
                end else if (sub && ssum[32]) begin
                    latched_err = ERR_SUBSET_OVF;
                end else begin
                    if (feat) begin
                        col_total[ci] = tsum[31:0];
                        col_hits[ci]  = col_hits[ci] + 1;
                    end
                    if (sub)
                        col_subset[ci] = ssum[31:0];
                    prev_row         = row;
                    prev_col         = col;
                    accepted_entries = accepted_entries + 1;
                end
            end
        end else if (col_usable(col)) begin
            rep.total  = col_total[col - 1];
            rep.hits   = col_hits[col - 1];
            rep.subset = col_subset[col - 1];
        end
        rep.err      = latched_err;
        rep.complete = accepted_entries == cfg_entry_total;
        return rep;
    endfunction

    // picks an entry that keeps the stream clean, or returns 0 when none fits
    function automatic bit pick_entry(output logic [31:0] row, output logic [15:0] col,
                                      output logic [31:0] val);
        bit [63:0] lo;
        bit [63:0] hi;
        bit [63:0] r;
        bit [63:0] c;
        bit [63:0] top;
        bit [63:0] room;
        bit        stay;
        int        attempt;
        row = '0;
        col = '0;
        val = '0;
        if (accepted_entries >= cfg_entry_total || cfg_rows == 0)
            return 1'b0;
        // the last column stays untouched for the closing test
        top  = (cfg_cols < NCOL) ? cfg_cols : NCOL - 1;
        hi   = cfg_rows;
        stay = prev_col != 0 && prev_col <= top && prev_row < cfg_rows &&
               $urandom_range(3, 0) != 0;
        for (attempt = 0; attempt < 2; attempt++) begin
            if (stay) begin
                c  = prev_col;
                lo = 64'(prev_row) + 1;
            end else begin
                c  = 64'(prev_col) + $urandom_range(3, 1);
                lo = 1;
                if (c > top)
                    return 1'b0;
            end
            case ($urandom_range(7, 0))
                0:       r = hi;
                1, 2, 3: r = lo + $urandom_range(32'((hi - lo > 15) ? 15 : hi - lo), 0);
                default: r = lo + $urandom_range(32'(hi - lo), 0);
            endcase
            // subset sum never exceeds the total, so the total bounds the headroom
            room = (r <= cfg_feature_rows) ? 64'(ALL_ONES) - col_total[c - 1] : 64'(ALL_ONES);
            if (room != 0) begin
                case ($urandom_range(7, 0))
                    0:          val = room[31:0];
                    1, 2, 3, 4: val = 1 + $urandom_range(32'((room > 16'hFFFF) ? 16'hFFFE : room - 1), 0);
                    default:    val = 1 + $urandom_range(32'(room - 1), 0);
                endcase
                row = r[31:0];
                col = c[15:0];
                return 1'b1;
            end
            stay = 1'b0;
        end
        return 1'b0;
    endfunction

    function automatic logic [15:0] pick_read_col();
        case ($urandom_range(9, 0))
            0:       return 16'd0;
            1:       return 16'($urandom);
            2:       return 16'(cfg_cols);
            3:       return 16'(cfg_cols) + 16'd1;
            4:       return 16'(NCOL + $urandom_range(1, 0));
            default: return 16'($urandom_range(32'(prev_col) + 2, 1));
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        n_mismatch++;
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        case (idx)
            REG_ROW_COUNT:    cfg_rows         = data;
            REG_COL_COUNT:    cfg_cols         = data[12:0];
            REG_ENTRY_TOTAL:  cfg_entry_total  = data;
            REG_FEATURE_ROWS: cfg_feature_rows = data;
            REG_SUBSET_FIRST: cfg_sub_first    = data;
            REG_SUBSET_LAST:  cfg_sub_last     = data;
            default: ;
        endcase
    endtask

    task automatic cfg_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_item(input logic m, input logic [31:0] row, input logic [15:0] col,
                             input logic [31:0] val);
        int unsigned gap;
        gap = burst ? 0 : $urandom_range(16, 0);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        mode        <= m;
        row_index   <= row;
        col_index   <= col;
        entry_value <= val;
        do @(posedge clk); while (busy !== 1'b0);
        column_reports_due.push_back(column_report_for(m, row, col, val));
        n_sent++;
        if (m)
            n_reads++;
    endtask

    task automatic send_read(input logic [15:0] col);
        send_item(1'b1, $urandom, col, $urandom);
    endtask

    // waits until every outstanding result has been checked; returns at once when none is due
    task automatic drain_results();
        start <= 1'b0;
        while (column_reports_due.size() != 0) @(posedge clk);
    endtask

    task automatic test_cleared_store_and_edges();
        cfg_write(REG_ROW_COUNT, ALL_ONES);
        cfg_write(REG_COL_COUNT, 32'd4096);
        cfg_write(REG_ENTRY_TOTAL, 32'd7);
        cfg_write(REG_FEATURE_ROWS, 32'h8000_0000);
        cfg_write(REG_SUBSET_FIRST, 32'd3);
        cfg_write(REG_SUBSET_LAST, 32'h7FFF_FFFF);
        cfg_write(REG_SPARE_A, 32'd0);
        cfg_write(REG_SPARE_B, ALL_ONES);
        cfg_release();
        send_read(16'd1);
        send_read(16'd4096);
        send_read(16'd0);
        send_read(16'd4097);
        send_read(16'hFFFF);
        // first column: one full-scale feature entry, then rows past the feature boundary
        send_item(1'b0, 32'd1, 16'd1, ALL_ONES);
        send_item(1'b0, 32'h8000_0001, 16'd1, ALL_ONES);
        send_item(1'b0, ALL_ONES, 16'd1, 32'd1);
        send_read(16'd1);
        // second column hits both subset edges and the feature edge, total ends at all ones
        send_item(1'b0, 32'd3, 16'd2, 32'd5);
        send_item(1'b0, 32'h7FFF_FFFF, 16'd2, 32'hFFFF_FFF0);
        send_item(1'b0, 32'h8000_0000, 16'd2, 32'd10);
        send_read(16'd2);
        send_item(1'b0, 32'd2, 16'd3, 32'h8000_0001);
        send_read(16'd3);
    endtask

    task automatic test_column_streams();
        int unsigned k;
        int unsigned n_random;
        logic [31:0] r;
        logic [31:0] v;
        logic [31:0] first;
        logic [15:0] c;
        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            drain_results();
            k = $urandom_range(160, 40);
            case ($urandom_range(3, 0))
                0:       cfg_write(REG_ROW_COUNT, $urandom);
                1:       cfg_write(REG_ROW_COUNT, $urandom_range(1000, 1));
                default: cfg_write(REG_ROW_COUNT, ALL_ONES);
            endcase
            case ($urandom_range(9, 0))
                0:       cfg_write(REG_COL_COUNT, 32'd0);
                1:       cfg_write(REG_COL_COUNT, ALL_ONES);
                2:       cfg_write(REG_COL_COUNT, 32'h0001_1000);
                3, 4:    cfg_write(REG_COL_COUNT, 32'(prev_col) + $urandom_range(300, 20));
                default: cfg_write(REG_COL_COUNT, 32'd4096);
            endcase
            cfg_write(REG_ENTRY_TOTAL, accepted_entries + $urandom_range(k, k / 2));
            case ($urandom_range(5, 0))
                0:       cfg_write(REG_FEATURE_ROWS, 32'd0);
                1:       cfg_write(REG_FEATURE_ROWS, $urandom);
                2:       cfg_write(REG_FEATURE_ROWS, $urandom_range(2000, 1));
                default: cfg_write(REG_FEATURE_ROWS, ALL_ONES);
            endcase
            first = $urandom_range(1, 0) ? $urandom_range(64, 1) : $urandom;
            cfg_write(REG_SUBSET_FIRST, first);
            case ($urandom_range(3, 0))
                0:       cfg_write(REG_SUBSET_LAST, $urandom);
                1:       cfg_write(REG_SUBSET_LAST, ALL_ONES);
                default: cfg_write(REG_SUBSET_LAST, first + $urandom_range(5000, 0));
            endcase
            cfg_release();
            burst = $urandom_range(3, 0) == 0;
            repeat (k) begin
                if ($urandom_range(3, 0) == 0 || !pick_entry(r, c, v))
                    send_read(pick_read_col());
                else
                    send_item(1'b0, r, c, v);
                if ($urandom_range(60, 0) == 0)
                    drain_results();
                n_random++;
            end
        end
        burst = 1'b0;
    endtask

    // only one error can ever latch, so each run closes on a randomly chosen one;
    // subset overflow cannot happen because a subset sum never exceeds its total
    task automatic test_error_latch();
        err_t        kind;
        int unsigned flavor;
        logic [31:0] row;
        logic [31:0] val;
        logic [15:0] col;
        drain_results();
        case ($urandom_range(3, 0))
            0:       kind = ERR_BAD;
            1:       kind = ERR_ORDER;
            2:       kind = ERR_TOTAL_OVF;
            default: kind = ERR_TOO_MANY;
        endcase
        flavor = $urandom_range(5, 0);
        cfg_write(REG_ROW_COUNT, $urandom_range(32'hFFFF_FFFE, 2));
        cfg_write(REG_COL_COUNT, (kind == ERR_BAD && flavor == 4) ? ALL_ONES : 32'd4096);
        cfg_write(REG_ENTRY_TOTAL, (kind == ERR_TOO_MANY) ? accepted_entries + 1 : ALL_ONES);
        cfg_write(REG_FEATURE_ROWS, ALL_ONES);
        cfg_write(REG_SUBSET_FIRST, 32'd1);
        cfg_write(REG_SUBSET_LAST, $urandom_range(32'hFFFF_FFFF, 1));
        cfg_release();
        // last clean entry fills the last column to the brim
        send_item(1'b0, 32'd1, 16'(NCOL), ALL_ONES);
        send_read(16'(NCOL));
        if (kind == ERR_TOO_MANY && $urandom_range(1, 0)) begin
            drain_results();
            cfg_write(REG_ENTRY_TOTAL, $urandom_range(accepted_entries - 1, 0));
            cfg_release();
        end
        row = 32'd2;
        col = 16'(NCOL);
        val = 32'd1;
        case (kind)
            ERR_BAD: begin
                case (flavor)
                    0:       row = 32'd0;
                    1:       row = $urandom_range(ALL_ONES, cfg_rows + 1);
                    2:       col = 16'd0;
                    3:       col = 16'($urandom_range(16'hFFFF, 32'(cfg_cols) + 1));
                    4:       col = 16'($urandom_range(32'h1FFF, NCOL + 1));
                    default: val = 32'd0;
                endcase
            end
            ERR_ORDER: begin
                row = 32'd1;
                if ($urandom_range(1, 0))
                    col = 16'($urandom_range(NCOL - 1, 1));
            end
            ERR_TOTAL_OVF: val = $urandom_range(ALL_ONES, 1);
            default: ;
        endcase
        send_item(1'b0, row, col, val);
        // entries after the error must leave every column alone
        repeat (NOISE_ITEMS) begin
            if ($urandom_range(1, 0))
                send_read(pick_read_col());
            else
                send_item(1'b0, $urandom, 16'($urandom), $urandom);
        end
        drain_results();
    endtask

    always @(posedge clk) begin : check_results
        column_report_t want;
        if (rst_n && done === 1'b1) begin
            if (column_reports_due.size() == 0) begin
                report_mismatch("result with no transfer outstanding", total_sum, '0);
            end else begin
                want = column_reports_due.pop_front();
                n_checked++;
                if (total_sum !== want.total)
                    report_mismatch("total_sum", total_sum, want.total);
                if (hit_count !== want.hits)
                    report_mismatch("hit_count", hit_count, want.hits);
                if (subset_sum !== want.subset)
                    report_mismatch("subset_sum", subset_sum, want.subset);
                if (error_code !== want.err)
                    report_mismatch("error_code", 32'(error_code), 32'(want.err));
                if (entries_complete !== want.complete)
                    report_mismatch("entries_complete", 32'(entries_complete),
                                    32'(want.complete));
            end
        end
    end

    always @(posedge clk) begin
        if ((start && !busy) || done || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_cleared_store_and_edges();
        test_column_streams();
        test_error_latch();
        repeat (8) @(posedge clk);
        $display("run covered %0d items (%0d column reads), %0d entries taken, %0d results checked",
                 n_sent, n_reads, accepted_entries, n_checked);
        $display("stream closed on error %s, %0d mismatches", latched_err.name(), n_mismatch);
        if (n_mismatch == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
